// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/bced_pkg.sv -----
package bced_pkg;

	// Number of buttons held in the state table.
	localparam int BUTTONS = 4;
	// Index width, fixed by the sample format.
	localparam int BTN_W = 2;

	localparam logic [15:0] WINDOW_RST = 16'd400;
	localparam logic [15:0] LONG_RST   = 16'd1000;
	localparam logic [15:0] PERIOD_RST = 16'd200;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_WINDOW = 2'd0,
		REG_LONG   = 2'd1,
		REG_PERIOD = 2'd2,
		REG_NONE   = 2'd3
	} cfg_reg_t;

	// Event codes
	typedef enum logic [2:0] {
		EV_PRESS         = 3'd0,
		EV_DOUBLE        = 3'd1,
		EV_TRIPLE        = 3'd2,
		EV_LONG_RELEASE  = 3'd3,
		EV_SHORT_RELEASE = 3'd4,
		EV_CLICK         = 3'd5,
		EV_LONG          = 3'd6,
		EV_REPEAT        = 3'd7
	} ev_kind_t;

	// One state table entry
	typedef struct packed {
		logic        stable_level;
		logic        candidate_level;
		logic [1:0]  candidate_count;
		logic [1:0]  tap_count;
		logic        triple_done;
		logic        long_done;
		logic [31:0] press_time;
		logic [31:0] release_time;
		logic [31:0] repeat_deadline;
	} btn_state_t;

	typedef struct packed {
		logic [15:0] window_ms;
		logic [15:0] long_ms;
		logic [15:0] period_ms;
	} cfg_t;

	// Events raised by one sample
	typedef struct packed {
		logic [1:0] count;
		ev_kind_t   kind0;
		ev_kind_t   kind1;
	} ev_set_t;

endpackage

// ----- rtl/bced_state_mem.sv -----
module bced_state_mem (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [bced_pkg::BTN_W-1:0]      rd_addr,
	output bced_pkg::btn_state_t            rd_data,
	input  logic                            wr_en,
	input  logic [bced_pkg::BTN_W-1:0]      wr_addr,
	input  bced_pkg::btn_state_t            wr_data
);
	import bced_pkg::*;

	btn_state_t         mem [BUTTONS];
	logic [BUTTONS-1:0] valid_q;
	btn_state_t         rd_data_q;
	logic               rd_valid_q;

	// Storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Per-entry valid bits; an unwritten entry reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- rtl/bced_step.sv -----
module bced_step (
	input  bced_pkg::btn_state_t            cur,
	input  logic [bced_pkg::BTN_W-1:0]      button_index,
	input  logic                            raw_level,
	input  logic [31:0]                     time_ms,
	input  bced_pkg::cfg_t                  cfg,
	output bced_pkg::btn_state_t            nxt,
	output bced_pkg::ev_set_t               ev
);
	import bced_pkg::*;

	btn_state_t  s;
	logic        btn_ok;
	logic [15:0] long_t;
	logic [31:0] since_rel;
	logic [31:0] since_press;
	logic [31:0] to_deadline;
	logic        rel_in_window;

	assign btn_ok        = (32'(button_index) < BUTTONS);
	assign long_t        = (cfg.long_ms == 16'd0) ? 16'd1 : cfg.long_ms;
	// release_time is not changed before the press path reads it
	assign since_rel     = time_ms - cur.release_time;
	assign rel_in_window = (since_rel <= {16'd0, cfg.window_ms});

	// Debounce, edge handling and hold timing for one sample
	always_comb begin
		s           = cur;
		ev.count    = 2'd0;
		ev.kind0    = EV_PRESS;
		ev.kind1    = EV_PRESS;
		since_press = '0;
		to_deadline = '0;

		// click sequence expired while released
		if (!s.stable_level && s.tap_count != 2'd0 && !rel_in_window) begin
			s.tap_count   = 2'd0;
			s.triple_done = 1'b0;
		end

		if (raw_level == s.stable_level) begin
			s.candidate_count = 2'd0;
		end else begin
			if (raw_level != s.candidate_level) begin
				s.candidate_level = raw_level;
				s.candidate_count = 2'd1;
			end else if (s.candidate_count < 2'd2) begin
				s.candidate_count = s.candidate_count + 2'd1;
			end
			if (s.candidate_count >= 2'd2) begin
				s.stable_level    = raw_level;
				s.candidate_count = 2'd0;
				if (raw_level) begin
					// press
					s.press_time  = time_ms;
					s.long_done   = 1'b0;
					s.triple_done = 1'b0;
					ev.kind0      = EV_PRESS;
					ev.count      = 2'd1;
					if (s.tap_count != 2'd0 && rel_in_window) begin
						if (s.tap_count < 2'd3) begin
							s.tap_count = s.tap_count + 2'd1;
							if (s.tap_count == 2'd2) begin
								ev.kind1 = EV_DOUBLE;
								ev.count = 2'd2;
							end else if (s.tap_count == 2'd3) begin
								ev.kind1      = EV_TRIPLE;
								ev.count      = 2'd2;
								s.triple_done = 1'b1;
							end
						end
					end else begin
						s.tap_count = 2'd0;
					end
				end else if (s.long_done) begin
					// release after long press
					ev.kind0      = EV_LONG_RELEASE;
					ev.count      = 2'd1;
					s.tap_count   = 2'd0;
					s.triple_done = 1'b0;
				end else begin
					// short release
					ev.kind0 = EV_SHORT_RELEASE;
					ev.kind1 = EV_CLICK;
					ev.count = 2'd2;
					if (s.triple_done) begin
						s.tap_count   = 2'd0;
						s.triple_done = 1'b0;
					end else if (s.tap_count == 2'd0) begin
						s.tap_count = 2'd1;
					end
					s.release_time = time_ms;
				end
			end
		end

		// hold timing; never coincides with an edge event
		if (s.stable_level) begin
			since_press = time_ms - s.press_time;
			to_deadline = time_ms - s.repeat_deadline;
			if (!s.long_done && since_press >= {16'd0, long_t}) begin
				s.long_done       = 1'b1;
				s.tap_count       = 2'd0;
				s.triple_done     = 1'b0;
				s.repeat_deadline = s.press_time + {16'd0, long_t} + {16'd0, cfg.period_ms};
				ev.kind0          = EV_LONG;
				ev.count          = 2'd1;
			end else if (s.long_done && !to_deadline[31]) begin
				s.repeat_deadline = s.repeat_deadline + {16'd0, cfg.period_ms};
				ev.kind0          = EV_REPEAT;
				ev.count          = 2'd1;
			end
		end

		// out-of-range button: no change, no events
		if (!btn_ok) begin
			s        = cur;
			ev.count = 2'd0;
		end
		nxt = s;
	end

endmodule

// ----- rtl/bced_ev_out.sv -----
module bced_ev_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  bced_pkg::ev_set_t         ev,
	input  logic [2:0]                button_number,
	input  logic [31:0]               time_ms,
	output logic                      item_done,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [39:0]               m_axis_tdata,
	output logic [2:0]                m_axis_tuser,
	output logic                      m_axis_tlast
);
	import bced_pkg::*;

	logic        sel_q;
	logic        m_valid_q;
	logic [2:0]  number_q;
	logic [31:0] time_q;
	ev_kind_t    kind_q;
	logic        last_q;
	logic        out_free;
	logic        hand;
	logic        is_last;

	assign out_free  = !m_valid_q || m_axis_tready;
	assign is_last   = (ev.count == 2'd1) || sel_q;
	assign hand      = item_valid && (ev.count != 2'd0) && out_free;
	assign item_done = item_valid && ((ev.count == 2'd0) || (hand && is_last));

	// Event select and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (hand) begin
				sel_q     <= !is_last;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (hand) begin
			number_q <= button_number;
			time_q   <= time_ms;
			kind_q   <= sel_q ? ev.kind1 : ev.kind0;
			last_q   <= is_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, time_q, number_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

endmodule

// ----- rtl/button_click_event_detector_core.sv -----
// Channel   Dir  Word contents (lowest bit first)
// s_axis    in   tdata: button_index[1:0], raw_level, time_ms[31:0]
// m_axis    out  tdata: button_number[2:0], event_time_ms[31:0]; tuser: event_kind;
//                tlast: last event of a sample
// cfg       in   index: register number; data: 16-bit value; always ready
//
// A sample reads its button's entry in the state table, then is updated and
// written back in the update stage, with forwarding when the next sample hits
// the same button. The update stage hands one event per cycle to the output
// register while the output is free, and keeps a sample with two events until
// both are handed. Reset clears the table's valid bits at once; no clearing
// pass. Output stalls hold the update stage, which then holds the input.
module button_click_event_detector_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // button_index[1:0], raw_level[2], time_ms[34:3]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // button_number[2:0], event_time_ms[34:3]
	output logic [2:0]  m_axis_tuser,   // event_kind[2:0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bced_pkg::*;

	cfg_t             cfg_q;
	logic             accept;
	logic             done;
	logic             valid_s1;
	logic [BTN_W-1:0] idx_s1;
	logic             raw_s1;
	logic [31:0]      time_s1;
	logic             fwd_s1;
	btn_state_t       fwd_state_s1;
	btn_state_t       rd_state;
	btn_state_t       cur_state;
	btn_state_t       nxt_state;
	ev_set_t          ev;
	logic [BTN_W-1:0] in_idx;

	assign in_idx        = s_axis_tdata[BTN_W-1:0];
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !valid_s1 || done;
	assign cfg_ready     = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms <= WINDOW_RST;
			cfg_q.long_ms   <= LONG_RST;
			cfg_q.period_ms <= PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW: cfg_q.window_ms <= cfg_data;
				REG_LONG:   cfg_q.long_ms   <= cfg_data;
				REG_PERIOD: cfg_q.period_ms <= cfg_data;
				REG_NONE:   ;
			endcase
		end
	end

	// Update stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	// Sample fields and forwarding of a write-back that races the read
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1       <= in_idx;
			raw_s1       <= s_axis_tdata[BTN_W];
			time_s1      <= s_axis_tdata[BTN_W+32:BTN_W+1];
			fwd_s1       <= done && (idx_s1 == in_idx);
			fwd_state_s1 <= nxt_state;
		end
	end

	assign cur_state = fwd_s1 ? fwd_state_s1 : rd_state;

	bced_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (rd_state),
		.wr_en   (done),
		.wr_addr (idx_s1),
		.wr_data (nxt_state)
	);

	bced_step u_step (
		.cur          (cur_state),
		.button_index (idx_s1),
		.raw_level    (raw_s1),
		.time_ms      (time_s1),
		.cfg          (cfg_q),
		.nxt          (nxt_state),
		.ev           (ev)
	);

	bced_ev_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (valid_s1),
		.ev            (ev),
		.button_number ({1'b0, idx_s1} + 3'd1),
		.time_ms       (time_s1),
		.item_done     (done),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- rtl/bced_checker.sv -----
`include "assert_macros.svh"

module bced_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import bced_pkg::*;

	logic        out_wait;
	logic        out_take;
	logic [43:0] out_word;
	logic [2:0]  out_number;
	logic        run_head_kind;

	assign out_wait      = m_axis_tvalid && !m_axis_tready;
	assign out_take      = m_axis_tvalid && m_axis_tready;
	assign out_word      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
	assign out_number    = m_axis_tdata[2:0];
	assign run_head_kind = (m_axis_tuser == EV_PRESS) || (m_axis_tuser == EV_SHORT_RELEASE);

	// A stalled output word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, m_axis_tvalid && $stable(out_word))

	// Button numbers run from one to the button count
	`ASSERT_IMPLY(a_number_range, clk, arst_n, m_axis_tvalid, (out_number != 3'd0) && (out_number <= 3'(BUTTONS)))

	// Only a press or a short release opens a two-event run
	`ASSERT_IMPLY(a_run_head, clk, arst_n, m_axis_tvalid && !m_axis_tlast, run_head_kind)

	// The second event of a run follows at once with same button and time
	`ASSERT_NEXT(a_run_tail, clk, arst_n, out_take && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && $stable(m_axis_tdata))

endmodule

bind button_click_event_detector_core bced_checker u_bced_checker (.*);
